>>> hw/rtl/bas_pkg.sv
// Package with register codes, widths and the channel blend function of the scaler.
package bas_pkg;

   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned SCALE_W = 24;
   localparam int unsigned SIZE_W  = 9;
   localparam int unsigned COORD_W = 12;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_W    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_H    = 3'd3;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef logic [SIZE_W-1:0] coord_type;
   typedef logic [7:0]        weight_type;
   typedef logic [PIXEL_W-1:0] pixel_type;

   // c0 + floor((c1-c0)*w/256), kept non-negative by adding 256 first
   function automatic logic [7:0] blend_chan(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] w);
      logic [8:0]  shifted;
      logic [16:0] prod;
      logic [9:0]  sum;
      shifted = 9'd256 + {1'b0, c1} - {1'b0, c0};
      prod    = shifted * w;
      sum     = {2'b00, c0} + {1'b0, prod[16:8]} - {2'b00, w};
      return sum[7:0];
   endfunction

   function automatic pixel_type blend_pixel(input pixel_type p0, input pixel_type p1,
                                             input logic [7:0] w);
      pixel_type r;
      for (int i = 0; i < 4; i++) begin
         r[8*i +: 8] = blend_chan(p0[8*i +: 8], p1[8*i +: 8], w);
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/bas_axis.sv
// Coordinate mapper for one axis: two stages from destination coordinate to neighbours and weight.
module bas_axis (
   input  logic                        clock,
   input  logic [bas_pkg::SCALE_W-1:0] scale,
   input  logic [bas_pkg::COORD_W-1:0] dest,
   input  logic [bas_pkg::SIZE_W-1:0]  size,
   output bas_pkg::coord_type          first,
   output bas_pkg::coord_type          next,
   output bas_pkg::weight_type         weight
);

   localparam int unsigned T_W = bas_pkg::SCALE_W + bas_pkg::COORD_W + 1;

   logic [T_W-1:0]   t_ff;
   logic [T_W-2:0]   pos;
   logic [T_W-18:0]  ip;
   logic [bas_pkg::SIZE_W-1:0] last;
   bas_pkg::coord_type  first_in, first_ff, next_ff;
   bas_pkg::weight_type weight_ff;

   always_ff @(posedge clock) begin
      t_ff <= scale * {dest, 1'b1};
   end

   always_comb begin
      logic [T_W-1:0] diff;
      diff = t_ff - T_W'(65536);
      pos  = (t_ff <= T_W'(65536)) ? '0 : diff[T_W-1:1];
      ip   = pos[T_W-2:16];
      last = size - bas_pkg::SIZE_W'(1);
      first_in = (ip > {{(T_W-17-bas_pkg::SIZE_W){1'b0}}, last}) ? last
                                                                   : ip[bas_pkg::SIZE_W-1:0];
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      next_ff   <= (first_in < last) ? first_in + bas_pkg::SIZE_W'(1) : first_in;
      weight_ff <= pos[15:8];
   end

   assign first  = first_ff;
   assign next   = next_ff;
   assign weight = weight_ff;

endmodule

>>> hw/rtl/bilinear_argb_scaler_core.sv
// Top level of the bilinear ARGB scaler: source image store, neighbour fetch and blend pipeline.
// rsp_valid is registered alongside the result pixel; the receiver cannot stall it.
// Throughput: one item per cycle; busy stays low, a load or a sample may start every cycle.
// The store is two copies of the image, each with two read ports, so all four neighbours
// come out in the same cycle; loads write both copies at the stage where samples read.
// Reset clears the pipeline valids and the CSRs; the image store is undefined until loaded.
module bilinear_argb_scaler_core #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [bas_pkg::ADDR_W-1:0]    req_load_index,
   input  logic [bas_pkg::PIXEL_W-1:0]   req_load_pixel,
   input  logic [bas_pkg::COORD_W-1:0]   req_dest_x,
   input  logic [bas_pkg::COORD_W-1:0]   req_dest_y,
   output logic                          rsp_valid,
   output logic [bas_pkg::PIXEL_W-1:0]   rsp_out_pixel,
   input  logic                          csr_we,
   input  logic [bas_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bas_pkg::SCALE_W-1:0]   csr_wdata
);

   localparam int unsigned CMP_W = 13;
   localparam int unsigned DEPTH = 1 << bas_pkg::ADDR_W;

   // Configuration registers
   logic [bas_pkg::SCALE_W-1:0] scale_x_ff, scale_y_ff;
   logic [bas_pkg::SIZE_W-1:0]  src_w_ff, src_h_ff;
   logic [bas_pkg::SIZE_W-1:0]  eff_w, eff_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= bas_pkg::SCALE_W'(65536);
         scale_y_ff <= bas_pkg::SCALE_W'(65536);
         src_w_ff   <= bas_pkg::SIZE_W'(256);
         src_h_ff   <= bas_pkg::SIZE_W'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            bas_pkg::CSR_SCALE_X: scale_x_ff <= csr_wdata;
            bas_pkg::CSR_SCALE_Y: scale_y_ff <= csr_wdata;
            bas_pkg::CSR_SRC_W:   src_w_ff   <= csr_wdata[bas_pkg::SIZE_W-1:0];
            bas_pkg::CSR_SRC_H:   src_h_ff   <= csr_wdata[bas_pkg::SIZE_W-1:0];
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // Clamp the sizes: zero counts as one, anything past the maximum is the maximum
   always_comb begin
      priority if (src_w_ff == '0)
         eff_w = bas_pkg::SIZE_W'(1);
      else if ({{(CMP_W-bas_pkg::SIZE_W){1'b0}}, src_w_ff} > CMP_W'(MAX_WIDTH))
         eff_w = bas_pkg::SIZE_W'(MAX_WIDTH);
      else
         eff_w = src_w_ff;
      priority if (src_h_ff == '0)
         eff_h = bas_pkg::SIZE_W'(1);
      else if ({{(CMP_W-bas_pkg::SIZE_W){1'b0}}, src_h_ff} > CMP_W'(MAX_HEIGHT))
         eff_h = bas_pkg::SIZE_W'(MAX_HEIGHT);
      else
         eff_h = src_h_ff;
   end

   assign busy = 1'b0;

   wire accept = start && !busy;

   // Stages 1 and 2: map both axes
   bas_pkg::coord_type  x0, x1, y0, y1;
   bas_pkg::weight_type wx, wy;

   bas_axis u_axis_x (
      .clock (clock), .scale (scale_x_ff), .dest (req_dest_x), .size (eff_w),
      .first (x0), .next (x1), .weight (wx)
   );

   bas_axis u_axis_y (
      .clock (clock), .scale (scale_y_ff), .dest (req_dest_y), .size (eff_h),
      .first (y0), .next (y1), .weight (wy)
   );

   // Item control and load payload travel alongside the mapper stages
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic f1_ff, f2_ff;
   logic [bas_pkg::ADDR_W-1:0]  idx1_ff, idx2_ff;
   bas_pkg::pixel_type          pix1_ff, pix2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         // only samples carry on past the store
         v3_ff        <= v2_ff && (f2_ff == bas_pkg::FUNC_SAMPLE);
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_ff   <= req_func;
      idx1_ff <= req_load_index;
      pix1_ff <= req_load_pixel;
      f2_ff   <= f1_ff;
      idx2_ff <= idx1_ff;
      pix2_ff <= pix1_ff;
   end

   // Stage 3: addresses row*width+column, wrapped to the store depth
   logic [2*bas_pkg::SIZE_W-1:0] row0, row1;
   logic [bas_pkg::ADDR_W-1:0]   a00, a01, a10, a11;

   always_comb begin
      logic [2*bas_pkg::SIZE_W:0] s00, s01, s10, s11;
      row0 = y0 * eff_w;
      row1 = y1 * eff_w;
      s00  = {1'b0, row0} + {{(bas_pkg::SIZE_W+1){1'b0}}, x0};
      s01  = {1'b0, row0} + {{(bas_pkg::SIZE_W+1){1'b0}}, x1};
      s10  = {1'b0, row1} + {{(bas_pkg::SIZE_W+1){1'b0}}, x0};
      s11  = {1'b0, row1} + {{(bas_pkg::SIZE_W+1){1'b0}}, x1};
      a00  = s00[bas_pkg::ADDR_W-1:0];
      a01  = s01[bas_pkg::ADDR_W-1:0];
      a10  = s10[bas_pkg::ADDR_W-1:0];
      a11  = s11[bas_pkg::ADDR_W-1:0];
   end

   // Image store: two copies, each written by every load and read at two addresses.
   // A read returns the old word when a load writes the same address in the same cycle.
   bas_pkg::pixel_type mem_top [DEPTH];
   bas_pkg::pixel_type mem_bot [DEPTH];
   bas_pkg::pixel_type p00_ff, p01_ff, p10_ff, p11_ff;
   bas_pkg::weight_type wx3_ff, wy3_ff;

   wire wr_en = v2_ff && (f2_ff == bas_pkg::FUNC_LOAD);

   always_ff @(posedge clock) begin
      p00_ff <= mem_top[a00];
      p01_ff <= mem_top[a01];
      if (wr_en) begin
         mem_top[idx2_ff] <= pix2_ff;
      end
   end

   always_ff @(posedge clock) begin
      p10_ff <= mem_bot[a10];
      p11_ff <= mem_bot[a11];
      if (wr_en) begin
         mem_bot[idx2_ff] <= pix2_ff;
      end
   end

   always_ff @(posedge clock) begin
      wx3_ff <= wx;
      wy3_ff <= wy;
   end

   // Stage 4: horizontal blend of both rows
   bas_pkg::pixel_type  top_ff, bot_ff;
   bas_pkg::weight_type wy4_ff;

   always_ff @(posedge clock) begin
      top_ff <= bas_pkg::blend_pixel(p00_ff, p01_ff, wx3_ff);
      bot_ff <= bas_pkg::blend_pixel(p10_ff, p11_ff, wx3_ff);
      wy4_ff <= wy3_ff;
   end

   // Stage 5: vertical blend into the result register
   bas_pkg::pixel_type out_ff;

   always_ff @(posedge clock) begin
      out_ff <= bas_pkg::blend_pixel(top_ff, bot_ff, wy4_ff);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = out_ff;

endmodule
